[rtl/core/packed_symmetric_matrix_store_top_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the packed symmetric matrix store
// Shared forms for the concurrent checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef PACKED_SYMMETRIC_MATRIX_STORE_TOP_MACROS_SVH
`define PACKED_SYMMETRIC_MATRIX_STORE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high
`define PSMS_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high
`define PSMS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/psms_pkg.sv]
// ---------------------------------------------------------------------------
// psms_pkg
// Types, codes and the row-base helper shared by the matrix store files.
// ---------------------------------------------------------------------------
`default_nettype none

package psms_pkg;

  // Field widths
  localparam int IDX_W     = 6;
  localparam int DIM_REG_W = 7;
  localparam int OPERAND_W = 32;
  localparam int DATA_W    = 32;

  // Row-base helper covers vertex numbers up to 2047
  localparam int TRI_ARG_W = 11;
  localparam int TRI_RES_W = 21;

  localparam logic [DIM_REG_W-1:0] DIM_RESET = 7'd64;

  // Command codes
  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_SUB   = 2'd2,
    FUNC_SWAP  = 2'd3
  } func_t;

  localparam logic STATUS_DONE   = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef struct packed {
    func_t                func;
    logic [IDX_W-1:0]     index_a;
    logic [IDX_W-1:0]     index_b;
    logic [OPERAND_W-1:0] operand_value;
  } cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              status;
  } rsp_t;

  // Swap walker control from the top-level sequencer
  typedef struct packed {
    logic start;
    logic step;
  } walk_ctl_t;

  // First packed offset of row n: n*(n-1)/2
  function automatic logic [TRI_RES_W-1:0] tri_base(input logic [TRI_ARG_W-1:0] n);
    logic [2*TRI_ARG_W-1:0] prod;
    prod = (n == '0) ? '0 : n * (n - 1'b1);
    return prod[TRI_RES_W:1];
  endfunction

endpackage

`default_nettype wire

[rtl/core/packed_symmetric_matrix_store_top.sv]
// ---------------------------------------------------------------------------
// packed_symmetric_matrix_store_top
// Symmetric weight matrix with zero diagonal, lower triangle kept packed.
// ---------------------------------------------------------------------------
// After reset the block sweeps the cell memory to zero, one cell per cycle,
// and takes no command meanwhile; the dimension register can be written at
// any time. A rejected command, a read of the diagonal or a write is answered
// with no memory read; a read or subtract first reads the memory, then returns
// the data or writes the difference back; a vertex swap reads and writes pair
// by pair, since each exchanged pair needs two writes through the single
// memory write port. One command is in work at a time; a finished result
// waits in the output register while the next command is taken, or, if that
// register is still full, in a hold register while the input stalls.
// ---------------------------------------------------------------------------
`default_nettype none

`include "packed_symmetric_matrix_store_top_macros.svh"

module packed_symmetric_matrix_store_top import psms_pkg::*; #(
  parameter int MAX_DIM    = 64,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [DIM_REG_W-1:0]  cfg_wr_data,
  input  wire logic                  in_valid,
  output      logic                  in_stall,
  input  wire cmd_t                  in_data,
  output      logic                  out_valid,
  input  wire logic                  out_stall,
  output      rsp_t                  out_data
);

  localparam int CELL_COUNT = MAX_DIM * (MAX_DIM - 1) / 2;
  localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int DIM_W      = $clog2(MAX_DIM + 1);
  localparam int DW         = (DIM_W > DIM_REG_W) ? DIM_W : DIM_REG_W;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELL_COUNT - 1);

  typedef enum logic [7:0] {
    ST_CLEAR   = 8'b0000_0001,
    ST_IDLE    = 8'b0000_0010,
    ST_ACCESS  = 8'b0000_0100,
    ST_SW_INIT = 8'b0000_1000,
    ST_SW_RD   = 8'b0001_0000,
    ST_SW_WP   = 8'b0010_0000,
    ST_SW_WQ   = 8'b0100_0000,
    ST_HOLD    = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  // Cell memory, one write and two reads per cycle
  logic [VALUE_BITS-1:0] mem [CELL_COUNT];
  logic [VALUE_BITS-1:0] rdata_a, rdata_b;
  logic                  mem_we, mem_re;
  logic [ADDR_W-1:0]     mem_waddr, raddr_a, raddr_b;
  logic [VALUE_BITS-1:0] mem_wdata;

  // Configuration and clear sweep
  logic [DIM_REG_W-1:0]  dim_reg;
  logic [DW-1:0]         dim_ext, dim_use;
  logic [ADDR_W-1:0]     clr_addr;

  // Command decode
  logic [IDX_W-1:0]      lo, hi;
  logic                  out_of_range, same_idx, reject, trivial;
  logic [TRI_RES_W-1:0]  off_wide;
  logic [ADDR_W-1:0]     off;
  logic [63:0]           op_wide;
  logic [VALUE_BITS-1:0] val;

  // Held command
  func_t                 cmd_func;
  logic [ADDR_W-1:0]     cmd_addr;
  logic [VALUE_BITS-1:0] cmd_val;
  logic [IDX_W-1:0]      lo_r, hi_r;
  logic [DW-1:0]         dim_r;
  logic [ADDR_W-1:0]     pair_p, pair_q;

  // Swap walker
  walk_ctl_t             walk_ctl;
  logic [ADDR_W-1:0]     walk_p, walk_q;
  logic                  walk_done;

  // Result path
  logic                  fin, load_out, slot_free;
  rsp_t                  fin_rsp, pend_rsp;
  logic                  cap_cmd, cap_swap, cap_pair, cap_pend;
  logic [63:0]           rd_wide;

  // Dimension in use, limited to the storage size
  assign dim_ext = DW'(dim_reg);
  assign dim_use = (dim_ext > DW'(MAX_DIM)) ? DW'(MAX_DIM) : dim_ext;

  // Order the indices and check them
  assign lo           = (in_data.index_a < in_data.index_b) ? in_data.index_a
                                                            : in_data.index_b;
  assign hi           = (in_data.index_a < in_data.index_b) ? in_data.index_b
                                                            : in_data.index_a;
  assign out_of_range = DW'(hi) >= dim_use;
  assign same_idx     = lo == hi;
  assign reject       = out_of_range || (same_idx && in_data.func != FUNC_READ);
  assign trivial      = reject || same_idx;
  assign off_wide     = tri_base(TRI_ARG_W'(hi)) + TRI_RES_W'(lo);
  assign off          = off_wide[ADDR_W-1:0];
  assign op_wide      = 64'(in_data.operand_value);
  assign val          = op_wide[VALUE_BITS-1:0];
  assign rd_wide      = 64'(rdata_a);

  assign in_stall  = state != ST_IDLE;
  assign slot_free = !out_valid || !out_stall;

  psms_swap_walk #(
    .DW     (DW),
    .ADDR_W (ADDR_W)
  ) u_walk (
    .clk    (clk),
    .rst    (rst),
    .ctl    (walk_ctl),
    .lo     (lo_r),
    .hi     (hi_r),
    .dim    (dim_r),
    .addr_p (walk_p),
    .addr_q (walk_q),
    .done   (walk_done)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    raddr_a    = '0;
    raddr_b    = '0;
    fin        = 1'b0;
    fin_rsp    = '{read_data: '0, status: STATUS_DONE};
    walk_ctl   = '0;
    cap_cmd    = 1'b0;
    cap_swap   = 1'b0;
    cap_pair   = 1'b0;
    load_out   = 1'b0;
    cap_pend   = 1'b0;

    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        if (clr_addr == LAST_ADDR) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (trivial) begin
            fin            = 1'b1;
            fin_rsp.status = reject ? STATUS_REJECT : STATUS_DONE;
          end else begin
            case (in_data.func)
              FUNC_WRITE: begin
                mem_we    = 1'b1;
                mem_waddr = off;
                mem_wdata = val;
                fin       = 1'b1;
              end
              FUNC_SWAP: begin
                cap_swap   = 1'b1;
                state_next = ST_SW_INIT;
              end
              default: begin
                mem_re     = 1'b1;
                raddr_a    = off;
                cap_cmd    = 1'b1;
                state_next = ST_ACCESS;
              end
            endcase
          end
        end
      end
      ST_ACCESS: begin
        fin = 1'b1;
        if (cmd_func == FUNC_SUB) begin
          mem_we    = 1'b1;
          mem_waddr = cmd_addr;
          mem_wdata = rdata_a - cmd_val;
        end else begin
          fin_rsp.read_data = rd_wide[DATA_W-1:0];
        end
      end
      ST_SW_INIT: begin
        walk_ctl.start = 1'b1;
        state_next     = ST_SW_RD;
      end
      ST_SW_WP: begin
        mem_we        = 1'b1;
        mem_waddr     = pair_p;
        mem_wdata     = rdata_b;
        walk_ctl.step = 1'b1;
        state_next    = ST_SW_WQ;
      end
      ST_HOLD: begin
        if (slot_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        // ST_SW_RD and ST_SW_WQ: finish or fetch the next pair
        if (state == ST_SW_WQ) begin
          mem_we    = 1'b1;
          mem_waddr = pair_q;
          mem_wdata = rdata_a;
        end
        if (walk_done) begin
          fin = 1'b1;
        end else begin
          mem_re     = 1'b1;
          raddr_a    = walk_p;
          raddr_b    = walk_q;
          cap_pair   = 1'b1;
          state_next = ST_SW_WP;
        end
      end
    endcase

    // Finished result goes out now, or waits for the output register
    if (fin) begin
      if (slot_free) begin
        load_out   = 1'b1;
        state_next = ST_IDLE;
      end else begin
        cap_pend   = 1'b1;
        state_next = ST_HOLD;
      end
    end
  end

  // Cell memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      dim_reg   <= DIM_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cfg_wr_en) begin
        dim_reg <= cfg_wr_data;
      end
      out_valid <= load_out || (out_valid && out_stall);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cap_cmd) begin
      cmd_func <= in_data.func;
      cmd_addr <= off;
      cmd_val  <= val;
    end
    if (cap_swap) begin
      lo_r  <= lo;
      hi_r  <= hi;
      dim_r <= dim_use;
    end
    if (cap_pair) begin
      pair_p <= walk_p;
      pair_q <= walk_q;
    end
    if (cap_pend) begin
      pend_rsp <= fin_rsp;
    end
    if (load_out) begin
      out_data <= (state == ST_HOLD) ? pend_rsp : fin_rsp;
    end
  end

  // Checks
  `PSMS_ASSERT_NEXT(a_one_cmd_in_work, in_valid && !in_stall, in_stall || out_valid,
    "second command taken before the first one produced its result")
  `PSMS_ASSERT_NOW(a_swap_pair_distinct, state == ST_SW_WP, pair_p != pair_q,
    "swap pair maps both vertices to the same cell")
  `PSMS_ASSERT_NOW(a_swap_no_overlap, state == ST_SW_WQ && mem_re,
    mem_waddr != raddr_a && mem_waddr != raddr_b,
    "swap write-back collides with the next pair fetch")

endmodule

`default_nettype wire

[rtl/core/psms_swap_walk.sv]
// ---------------------------------------------------------------------------
// psms_swap_walk
// Steps through the cell pairs that a vertex swap exchanges: the columns
// below the smaller vertex, the span between the two, and the rows above
// the larger one. Gives the two packed offsets of the current pair.
// ---------------------------------------------------------------------------
`default_nettype none

module psms_swap_walk import psms_pkg::*; #(
  parameter int DW     = 7,
  parameter int ADDR_W = 11
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire walk_ctl_t             ctl,
  input  wire logic [IDX_W-1:0]      lo,
  input  wire logic [IDX_W-1:0]      hi,
  input  wire logic [DW-1:0]         dim,
  output      logic [ADDR_W-1:0]     addr_p,
  output      logic [ADDR_W-1:0]     addr_q,
  output      logic                  done
);

  typedef enum logic [2:0] {
    PH_LOW  = 3'b001,
    PH_MID  = 3'b010,
    PH_HIGH = 3'b100
  } phase_t;

  phase_t                ph, ph_next;
  logic [DW-1:0]         idx, idx_next;
  logic                  done_next;
  logic [TRI_RES_W-1:0]  tri_lo, tri_hi;
  logic [TRI_RES_W-1:0]  tri_i;
  logic [TRI_RES_W-1:0]  off_p, off_q;
  logic [DW-1:0]         lo_ext, hi_ext;

  assign lo_ext = DW'(lo);
  assign hi_ext = DW'(hi);

  // Next position, skipping the diagonal columns and empty ranges
  always_comb begin
    if (ctl.start) begin
      ph_next  = PH_LOW;
      idx_next = '0;
    end else begin
      ph_next  = ph;
      idx_next = idx + 1'b1;
    end
    done_next = 1'b0;
    if (ph_next == PH_LOW && idx_next >= lo_ext) begin
      ph_next  = PH_MID;
      idx_next = lo_ext + 1'b1;
    end
    if (ph_next == PH_MID && idx_next >= hi_ext) begin
      ph_next  = PH_HIGH;
      idx_next = hi_ext + 1'b1;
    end
    if (ph_next == PH_HIGH && idx_next >= dim) begin
      done_next = 1'b1;
    end
  end

  // Position registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ph   <= PH_LOW;
      idx  <= '0;
      done <= 1'b1;
    end else if (ctl.start || ctl.step) begin
      ph   <= ph_next;
      idx  <= idx_next;
      done <= done_next;
    end
  end

  // Row bases of the two vertices stay fixed for the whole swap
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      tri_lo <= tri_base(TRI_ARG_W'(lo));
      tri_hi <= tri_base(TRI_ARG_W'(hi));
    end
  end

  assign tri_i = tri_base(TRI_ARG_W'(idx));

  // Offsets of the pair at the current position
  always_comb begin
    case (ph)
      PH_LOW: begin
        off_p = tri_lo + TRI_RES_W'(idx);
        off_q = tri_hi + TRI_RES_W'(idx);
      end
      PH_MID: begin
        off_p = tri_i + TRI_RES_W'(lo);
        off_q = tri_hi + TRI_RES_W'(idx);
      end
      default: begin
        off_p = tri_i + TRI_RES_W'(lo);
        off_q = tri_i + TRI_RES_W'(hi);
      end
    endcase
  end

  assign addr_p = off_p[ADDR_W-1:0];
  assign addr_q = off_q[ADDR_W-1:0];

endmodule

`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: packed symmetric matrix store testbench
// Drives read, write, subtract and vertex-swap commands over several
// dimension settings, keeps a shadow copy of the packed triangle and checks
// every response in order against it. The sender bursts and idles, and the
// receiver stalls in patterns that include one long hold-off.
// ---------------------------------------------------------------------------
module tb;
  import psms_pkg::*;

  localparam int MAX_VERTS = 64;
  localparam int CELLS     = MAX_VERTS * (MAX_VERTS - 1) / 2;

  // Shadow of the matrix store plus the queue of responses still owed
  class weight_matrix_scoreboard;
    logic [DATA_W-1:0]    cells [CELLS];
    logic [DIM_REG_W-1:0] dim_reg;
    rsp_t                 owed_rsp [$];
    int                   errors;

    function new();
      foreach (cells[k]) cells[k] = '0;
      dim_reg = DIM_RESET;
      errors  = 0;
    endfunction

    function int dim_in_use();
      return (dim_reg > MAX_VERTS) ? MAX_VERTS : int'(dim_reg);
    endfunction

    function int tri_offset(int hi, int lo);
      return hi * (hi - 1) / 2 + lo;
    endfunction

    function void exchange(int p, int q);
      logic [DATA_W-1:0] t;
      t        = cells[p];
      cells[p] = cells[q];
      cells[q] = t;
    endfunction

    // Exchange every row and column cell of vertices lo and hi
    function void swap_vertices(int lo, int hi, int dim);
      for (int k = 0; k < lo; k++) exchange(tri_offset(lo, k), tri_offset(hi, k));
      for (int k = lo + 1; k < hi; k++) exchange(tri_offset(k, lo), tri_offset(hi, k));
      for (int k = hi + 1; k < dim; k++) exchange(tri_offset(k, lo), tri_offset(k, hi));
    endfunction

    function rsp_t apply_cmd(cmd_t c);
      rsp_t r;
      int   lo, hi, dim, off;
      r.read_data = '0;
      r.status    = STATUS_DONE;
      dim = dim_in_use();
      lo  = (c.index_a < c.index_b) ? int'(c.index_a) : int'(c.index_b);
      hi  = (c.index_a < c.index_b) ? int'(c.index_b) : int'(c.index_a);
      if (hi >= dim) begin
        r.status = STATUS_REJECT;
      end else if (lo == hi) begin
        // diagonal: reads answer zero, anything else is refused
        if (c.func != FUNC_READ) r.status = STATUS_REJECT;
      end else begin
        off = tri_offset(hi, lo);
        case (c.func)
          FUNC_READ:  r.read_data = cells[off];
          FUNC_WRITE: cells[off] = c.operand_value;
          FUNC_SUB:   cells[off] = cells[off] - c.operand_value;
          FUNC_SWAP:  swap_vertices(lo, hi, dim);
          default: ;
        endcase
      end
      return r;
    endfunction

    task report(string msg);
      if (errors < 50) $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    function void note_cmd(cmd_t c);
      owed_rsp = {owed_rsp, apply_cmd(c)};
    endfunction

    task check_rsp(rsp_t got);
      rsp_t want;
      if (owed_rsp.size() == 0) begin
        report($sformatf("unexpected response data=%h status=%b", got.read_data, got.status));
      end else begin
        want = owed_rsp.pop_front();
        if (got.read_data !== want.read_data)
          report($sformatf("read_data %h, expected %h", got.read_data, want.read_data));
        if (got.status !== want.status)
          report($sformatf("status %b, expected %b", got.status, want.status));
      end
    endtask

    function int pending();
      return owed_rsp.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [DIM_REG_W-1:0] cfg_wr_data;
  logic                 in_valid;
  logic                 in_stall;
  cmd_t                 in_data;
  logic                 out_valid;
  logic                 out_stall;
  rsp_t                 out_data;
  bit                   hold_req = 1'b0;

  weight_matrix_scoreboard sb = new();

  packed_symmetric_matrix_store_top dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Response monitor: a transfer completes at the edge with valid and no stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_rsp(out_data);
  end

  // Receiver: stall patterns in random spans, plus one long hold-off on request
  initial begin
    int mode, span;
    out_stall = 1'b0;
    forever begin
      if (hold_req) begin
        repeat (300) @(negedge clk) out_stall <= 1'b1;
        hold_req = 1'b0;
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(20, 150);
        repeat (span) begin
          @(negedge clk);
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= $urandom_range(0, 1);
            2: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 4) != 0);
          endcase
        end
      end
    end
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Offer one command and hold it until the transfer happens
  task automatic send_cmd(input cmd_t c);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_cmd(c);
  endtask

  task automatic idle_gap(input int n);
    repeat (n) @(negedge clk) in_valid <= 1'b0;
  endtask

  // Stop offering, wait for every owed response, then let the block go quiet
  task automatic settle();
    @(negedge clk) in_valid <= 1'b0;
    while (sb.pending() > 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_dim(input logic [DIM_REG_W-1:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sb.dim_reg = v;
  endtask

  function automatic cmd_t mk_cmd(func_t f, int a, int b, logic [OPERAND_W-1:0] v);
    cmd_t c;
    c.func          = f;
    c.index_a       = IDX_W'(a);
    c.index_b       = IDX_W'(b);
    c.operand_value = v;
    return c;
  endfunction

  // Mostly in range, with weight on the low and high vertex corners
  function automatic logic [IDX_W-1:0] pick_index(int dim);
    int r;
    r = $urandom_range(0, 99);
    if (r < 12 || dim < 1) return IDX_W'($urandom_range(0, 63));
    if (r < 45 && dim > 8)
      return (r < 28) ? IDX_W'($urandom_range(0, 3))
                      : IDX_W'(dim - 1 - int'($urandom_range(0, 3)));
    return IDX_W'($urandom_range(0, dim - 1));
  endfunction

  function automatic cmd_t random_cmd(int dim);
    cmd_t c;
    int   r;
    r = $urandom_range(0, 99);
    if (r < 30)      c.func = FUNC_READ;
    else if (r < 58) c.func = FUNC_WRITE;
    else if (r < 85) c.func = FUNC_SUB;
    else             c.func = FUNC_SWAP;
    c.index_a = pick_index(dim);
    c.index_b = ($urandom_range(0, 11) == 0) ? c.index_a : pick_index(dim);
    case ($urandom_range(0, 5))
      0:       c.operand_value = '0;
      1:       c.operand_value = '1;
      2:       c.operand_value = $urandom_range(0, 15);
      default: c.operand_value = $urandom();
    endcase
    return c;
  endfunction

  // Bursts of random length separated by random gaps
  task automatic run_random(input int count);
    int sent, burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        if (sent < count) begin
          send_cmd(random_cmd(sb.dim_in_use()));
          sent++;
        end
      end
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 8));
    end
  endtask

  initial begin
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    in_data     = '0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed: extremes, each command, diagonal and equal-index cases
    send_cmd(mk_cmd(FUNC_READ, 0, 1, '0));
    send_cmd(mk_cmd(FUNC_WRITE, 1, 0, 32'hFFFF_FFFF));
    send_cmd(mk_cmd(FUNC_READ, 0, 1, '0));
    send_cmd(mk_cmd(FUNC_SUB, 1, 0, 32'd1));
    send_cmd(mk_cmd(FUNC_WRITE, 63, 0, 32'h8000_0001));
    send_cmd(mk_cmd(FUNC_WRITE, 62, 63, 32'hA5A5_A5A5));
    send_cmd(mk_cmd(FUNC_SUB, 0, 63, 32'hFFFF_FFFF));
    send_cmd(mk_cmd(FUNC_SUB, 5, 7, 32'd1));
    send_cmd(mk_cmd(FUNC_READ, 7, 5, '1));
    send_cmd(mk_cmd(FUNC_READ, 5, 5, '1));
    send_cmd(mk_cmd(FUNC_READ, 63, 63, '0));
    send_cmd(mk_cmd(FUNC_WRITE, 5, 5, 32'h1234_5678));
    send_cmd(mk_cmd(FUNC_SUB, 9, 9, 32'd3));
    send_cmd(mk_cmd(FUNC_SWAP, 3, 3, '0));
    send_cmd(mk_cmd(FUNC_SWAP, 0, 63, '0));
    send_cmd(mk_cmd(FUNC_READ, 63, 1, '0));
    send_cmd(mk_cmd(FUNC_READ, 0, 63, '0));
    send_cmd(mk_cmd(FUNC_READ, 0, 62, '0));
    send_cmd(mk_cmd(FUNC_SWAP, 62, 1, '0));
    send_cmd(mk_cmd(FUNC_READ, 62, 63, '0));
    send_cmd(mk_cmd(FUNC_READ, 1, 63, '0));
    send_cmd(mk_cmd(FUNC_READ, 7, 5, '0));
    settle();

    // Random phases over several dimensions; long receiver hold-off in the first
    hold_req = 1'b1;
    run_random(200);
    settle();
    write_dim(7'd2);
    run_random(60);
    settle();
    write_dim(7'd127);
    run_random(150);
    settle();
    write_dim(7'd0);
    run_random(25);
    settle();
    write_dim(7'd1);
    run_random(25);
    settle();
    write_dim(7'd17);
    run_random(150);
    settle();
    write_dim(7'd5);
    run_random(80);
    settle();
    write_dim(7'd64);
    run_random(120);
    settle();
    write_dim(7'd40);
    run_random(60);
    settle();
    repeat (20) @(negedge clk);

    if (sb.pending() > 0) sb.report($sformatf("%0d responses never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/psms_pkg.sv
rtl/core/psms_swap_walk.sv
rtl/core/packed_symmetric_matrix_store_top.sv
bench/tb.sv
